[rtl/infix_expression_evaluator_assert.svh]
// Assertion macros for the evaluator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define IEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define IEE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define IEE_ASSERT(label, prop, msg)
`define IEE_NEVER(label, cond, msg)
`endif
`endif

[rtl/iee_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  // Character classes handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_DIGIT,
    CMD_DOT,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  digit;
    logic        last;
  } cmd_t;

  // Request to and status from the iterative multiply / divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // ASCII codes of interest.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int QUEUE_DEPTH = 2;
  localparam int FDC_W       = 3;
  localparam int POW_W       = 20;

  // Power of ten for a fraction digit count, capped at six digits.
  function automatic logic [POW_W-1:0] pow_ten(input logic [FDC_W-1:0] n);
    logic [POW_W-1:0] p;
    unique case (n)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      default: p = 20'd1000000;
    endcase
    return p;
  endfunction

endpackage

[rtl/iee_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_front
// Input stage: classify each character and register it for the command queue.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_stall,
  input  logic [7:0]    char_code,
  input  logic          is_final,
  output iee_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import iee_pkg::*;

  cmd_t       cls;
  logic       keep;
  logic       accept;
  logic [3:0] offs;

  always_comb begin
    offs      = 4'(char_code - CH_ZERO);
    cls.digit = offs;
    cls.last  = is_final;
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      cls.kind = CMD_DIGIT;
    end else if (char_code == CH_DOT) begin
      cls.kind = CMD_DOT;
    end else if (char_code == CH_PLUS) begin
      cls.kind = CMD_ADD;
    end else if (char_code == CH_MINUS) begin
      cls.kind = CMD_SUB;
    end else if (char_code == CH_STAR) begin
      cls.kind = CMD_MUL;
    end else if (char_code == CH_SLASH) begin
      cls.kind = CMD_DIV;
    end else begin
      cls.kind = CMD_NONE;
    end
  end

  // Drop ignored characters unless they close the expression.
  assign keep       = (cls.kind != CMD_NONE) || is_final;
  assign char_stall = cmd_valid && !cmd_ready;
  assign accept     = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_ready) begin
      cmd_valid <= accept && keep;
    end
    if (accept) begin
      cmd <= cls;
    end
  end

endmodule

[rtl/iee_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module iee_queue (
  input  logic          clk,
  input  logic          rst,
  input  iee_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output iee_pkg::cmd_t pop_cmd,
  output logic          pop_valid,
  input  logic          pop
);
  import iee_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count < (PW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/iee_arith.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_arith
// Iterative unit: restoring divider (one quotient bit a cycle) and
// shift-add multiplier (one multiplier bit a cycle).
// ----------------------------------------------------------------------------
module iee_arith #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  iee_pkg::arith_req_t            req,
  input  logic [VALUE_WIDTH+FRAC_BITS:0] div_dvd,
  input  logic [VALUE_WIDTH-1:0]         mul_a,
  input  logic [VALUE_WIDTH-1:0]         arith_b,
  output iee_pkg::arith_rsp_t            rsp,
  output logic [VALUE_WIDTH+FRAC_BITS:0] quo,
  output logic [2*VALUE_WIDTH-1:0]       prod
);
  import iee_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int DW = VALUE_WIDTH + FRAC_BITS + 1;
  localparam int CW = $clog2(DW);

  logic          busy;
  logic          done;
  logic          is_div;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [W-1:0]  rem;
  logic [W-1:0]  den;
  logic [W-1:0]  mc;
  logic [2*W:0]  p;

  logic [W:0]    r2;
  logic [W:0]    rdiff;
  logic          ge;
  logic [W:0]    msum;
  logic [CW-1:0] last_cnt;

  always_comb begin
    r2       = {rem, dvd[DW-1]};
    ge       = r2 >= {1'b0, den};
    rdiff    = r2 - {1'b0, den};
    msum     = p[2*W:W] + (p[0] ? {1'b0, mc} : '0);
    last_cnt = is_div ? CW'(DW - 1) : CW'(W - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        cnt    <= '0;
        dvd    <= div_dvd;
        rem    <= '0;
        den    <= arith_b;
        mc     <= mul_a;
        p      <= {{(W+1){1'b0}}, arith_b};
      end else if (busy) begin
        if (is_div) begin
          rem <= ge ? rdiff[W-1:0] : r2[W-1:0];
          dvd <= {dvd[DW-2:0], ge};
        end else begin
          p <= {1'b0, msum, p[W-1:1]};
        end
        cnt <= cnt + 1'b1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign quo      = dvd;
  assign prod     = p[2*W-1:0];

endmodule

[rtl/iee_back.sv]
`timescale 1ns / 1ps
`include "infix_expression_evaluator_assert.svh"
// ----------------------------------------------------------------------------
// iee_back
// Execution sequencer: builds operands, applies products and quotients,
// accumulates terms and emits the result item.
// ----------------------------------------------------------------------------
module iee_back #(
  parameter int VALUE_WIDTH     = 48,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  iee_pkg::cmd_t                  cmd,
  input  logic                           cmd_valid,
  output logic                           cmd_pop,
  output iee_pkg::arith_req_t            req,
  output logic [VALUE_WIDTH+FRAC_BITS:0] div_dvd,
  output logic [VALUE_WIDTH-1:0]         mul_a,
  output logic [VALUE_WIDTH-1:0]         arith_b,
  input  iee_pkg::arith_rsp_t            rsp,
  input  logic [VALUE_WIDTH+FRAC_BITS:0] quo,
  input  logic [2*VALUE_WIDTH-1:0]       prod,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [VALUE_WIDTH-1:0]  value,
  output logic [1:0]                     status
);
  import iee_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = W + F + 1;
  localparam int PW = 2 * W - F;
  localparam int MW = (PW > DW) ? PW : DW;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_MUL  = 2'd1;
  localparam logic [1:0] PEND_DIV  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CONV, S_CWAIT, S_OPND, S_PWAIT, S_CLOSE, S_EMIT
  } state_t;

  state_t           state;
  cmd_t             cur;
  logic             fin_phase;
  logic [W-1:0]     sum;
  logic [W-1:0]     term;
  logic [W-1:0]     mant;
  logic [FDC_W-1:0] fdc;
  logic             in_frac;
  logic             neg;
  logic [1:0]       pend;
  logic [1:0]       err;
  logic [DW-1:0]    q;

  logic [W+3:0]     m10;
  logic             digit_skip;
  logic             m_ovf;
  logic [POW_W-1:0] den;
  logic [DW-1:0]    conv_num;
  logic             q_big;
  logic [W-1:0]     opnd_v;
  logic [W-1:0]     term_abs;
  logic [MW-1:0]    res_mag;
  logic             res_big;
  logic             res_min;
  logic [W-1:0]     sat_val;
  logic             sat_ovf;
  logic [W:0]       s_ext;
  logic             close_ovf;
  logic [W-1:0]     close_val;

  always_comb begin
    m10        = ({4'b0, mant} << 3) + ({4'b0, mant} << 1) + (W+4)'(cur.digit);
    digit_skip = in_frac && (fdc >= FDC_W'(MAX_FRAC_DIGITS));
    m_ovf      = |m10[W+3:W];
    den        = pow_ten(fdc);
    conv_num   = {1'b0, mant, {F{1'b0}}} + DW'(den >> 1);
    q_big      = |q[DW-1:W-1];
    opnd_v     = q_big ? VMAX : q[W-1:0];
    term_abs   = term[W-1] ? (~term + 1'b1) : term;
    res_mag    = (pend == PEND_MUL) ? MW'(prod[2*W-1:F]) : MW'(quo);
    res_big    = |res_mag[MW-1:W-1];
    res_min    = res_mag[W-1] && !(|res_mag[MW-1:W]) && !(|res_mag[W-2:0]);
    // Opnd is never negative, so the term's sign sets the result sign.
    if (!term[W-1]) begin
      sat_ovf = res_big;
      sat_val = res_big ? VMAX : res_mag[W-1:0];
    end else begin
      sat_ovf = res_big && !res_min;
      sat_val = sat_ovf ? VMIN : (~res_mag[W-1:0] + 1'b1);
    end
    s_ext     = neg ? ({sum[W-1], sum} - {term[W-1], term})
                    : ({sum[W-1], sum} + {term[W-1], term});
    close_ovf = s_ext[W] != s_ext[W-1];
    close_val = close_ovf ? (s_ext[W] ? VMIN : VMAX) : s_ext[W-1:0];
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fin_phase    <= 1'b0;
      sum          <= '0;
      term         <= '0;
      mant         <= '0;
      fdc          <= '0;
      in_frac      <= 1'b0;
      neg          <= 1'b0;
      pend         <= PEND_NONE;
      err          <= ST_OK;
      req          <= '0;
      result_valid <= 1'b0;
    end else begin
      // Start is raised only on the way into a wait state, so drop it there.
      if (req.start) begin
        req.start <= 1'b0;
      end
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (err == ST_DIVZERO) begin
            // Skip everything after a divide by zero.
            state <= cur.last ? S_EMIT : S_IDLE;
          end else begin
            case (cur.kind) inside
              CMD_DIGIT: begin
                if (!digit_skip) begin
                  if (in_frac) begin
                    fdc <= fdc + 1'b1;
                  end
                  if (m_ovf) begin
                    mant <= '1;
                    if (err == ST_OK) begin
                      err <= ST_OVERFLOW;
                    end
                  end else begin
                    mant <= m10[W-1:0];
                  end
                end
                fin_phase <= 1'b1;
                state     <= cur.last ? S_CONV : S_IDLE;
              end
              CMD_DOT: begin
                in_frac   <= 1'b1;
                fin_phase <= 1'b1;
                state     <= cur.last ? S_CONV : S_IDLE;
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                fin_phase <= 1'b0;
                state     <= S_CONV;
              end
              default: begin
                fin_phase <= 1'b1;
                state     <= cur.last ? S_CONV : S_IDLE;
              end
            endcase
          end
        end
        S_CONV: begin
          if (fdc == '0) begin
            q     <= {1'b0, mant, {F{1'b0}}};
            state <= S_OPND;
          end else begin
            req.start  <= 1'b1;
            req.is_div <= 1'b1;
            div_dvd    <= conv_num;
            arith_b    <= W'(den);
            state      <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (rsp.done) begin
            q     <= quo;
            state <= S_OPND;
          end
        end
        S_OPND: begin
          mant    <= '0;
          fdc     <= '0;
          in_frac <= 1'b0;
          if (q_big && err == ST_OK) begin
            err <= ST_OVERFLOW;
          end
          case (pend)
            PEND_MUL: begin
              req.start  <= 1'b1;
              req.is_div <= 1'b0;
              mul_a      <= term_abs;
              arith_b    <= opnd_v;
              state      <= S_PWAIT;
            end
            PEND_DIV: begin
              if (opnd_v == '0) begin
                err   <= ST_DIVZERO;
                state <= cur.last ? S_EMIT : S_IDLE;
              end else begin
                req.start  <= 1'b1;
                req.is_div <= 1'b1;
                div_dvd    <= {1'b0, term_abs, {F{1'b0}}};
                arith_b    <= opnd_v;
                state      <= S_PWAIT;
              end
            end
            default: begin
              term  <= opnd_v;
              state <= S_CLOSE;
            end
          endcase
        end
        S_PWAIT: begin
          if (rsp.done) begin
            term <= sat_val;
            if (sat_ovf && err == ST_OK) begin
              err <= ST_OVERFLOW;
            end
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (fin_phase) begin
            sum  <= close_val;
            term <= '0;
            if (close_ovf && err == ST_OK) begin
              err <= ST_OVERFLOW;
            end
            state <= S_EMIT;
          end else begin
            case (cur.kind) inside
              CMD_ADD, CMD_SUB: begin
                sum  <= close_val;
                term <= '0;
                if (close_ovf && err == ST_OK) begin
                  err <= ST_OVERFLOW;
                end
                neg  <= cur.kind == CMD_SUB;
                pend <= PEND_NONE;
              end
              CMD_MUL: pend <= PEND_MUL;
              CMD_DIV: pend <= PEND_DIV;
              default: ;
            endcase
            // An operator that ends the expression applies a zero operand.
            if (cur.last) begin
              fin_phase <= 1'b1;
              state     <= S_CONV;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            value        <= (err == ST_DIVZERO) ? '0 : sum;
            status       <= err;
            sum          <= '0;
            term         <= '0;
            mant         <= '0;
            fdc          <= '0;
            in_frac      <= 1'b0;
            neg          <= 1'b0;
            pend         <= PEND_NONE;
            err          <= ST_OK;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IEE_ASSERT(a_divzero_value, (result_valid && status == ST_DIVZERO) |-> (value == '0), "divide by zero result not zero")
  `IEE_NEVER(a_start_when_busy, req.start && rsp.busy, "arith request while unit busy")
  `IEE_ASSERT(a_done_in_wait, rsp.done |-> (state == S_CWAIT || state == S_PWAIT), "arith done outside wait state")
  `IEE_ASSERT(a_result_from_emit, $rose(result_valid) |-> ($past(state) == S_EMIT), "result raised outside emit")

endmodule

[rtl/infix_expression_evaluator.sv]
`timescale 1ns / 1ps
// Flow: an item passes the front-end register and the queue to the back end,
//   where a fractional operand and each multiply or divide also run on the
//   iterative unit before the item is done.
// Throughput: one item at a time in the back end; the front end keeps
//   accepting until its register and the two-entry queue fill.
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Streaming evaluator of + - * / expressions in signed fixed point.
// Spaces and other ignored characters are dropped at the front end unless
// they end the expression. Reset is synchronous and clears the control
// registers, with no clearing pass.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int VALUE_WIDTH     = 48,  // 24 to 64
  parameter int FRAC_BITS       = 16,  // 8 to 32
  parameter int MAX_FRAC_DIGITS = 4    // 1 to 6
) (
  input  logic                          clk,
  input  logic                          rst,
  // Character channel
  input  logic                          char_valid,
  output logic                          char_stall,
  input  logic [7:0]                    char_code,
  input  logic                          is_final,
  // Result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic [1:0]                    status
);
  import iee_pkg::*;

  // Front end to queue
  cmd_t       f_cmd;
  logic       f_valid;
  logic       q_ready;
  // Queue to back end
  cmd_t       q_cmd;
  logic       q_valid;
  logic       q_pop;
  // Back end to iterative unit
  arith_req_t                     a_req;
  arith_rsp_t                     a_rsp;
  logic [VALUE_WIDTH+FRAC_BITS:0] a_dvd;
  logic [VALUE_WIDTH-1:0]         a_mul;
  logic [VALUE_WIDTH-1:0]         a_b;
  logic [VALUE_WIDTH+FRAC_BITS:0] a_quo;
  logic [2*VALUE_WIDTH-1:0]       a_prod;

  // Classify characters; drop ignored ones that do not end the expression.
  iee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .is_final   (is_final),
    .cmd        (f_cmd),
    .cmd_valid  (f_valid),
    .cmd_ready  (q_ready)
  );

  // Decouple the front end from the slow back end.
  iee_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (q_ready),
    .pop_cmd    (q_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop)
  );

  // Sequence operand build, product/quotient, term accumulation and output.
  iee_back #(
    .VALUE_WIDTH     (VALUE_WIDTH),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (q_cmd),
    .cmd_valid    (q_valid),
    .cmd_pop      (q_pop),
    .req          (a_req),
    .div_dvd      (a_dvd),
    .mul_a        (a_mul),
    .arith_b      (a_b),
    .rsp          (a_rsp),
    .quo          (a_quo),
    .prod         (a_prod),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .status       (status)
  );

  // Shared bit-serial multiply and divide.
  iee_arith #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_arith (
    .clk     (clk),
    .rst     (rst),
    .req     (a_req),
    .div_dvd (a_dvd),
    .mul_a   (a_mul),
    .arith_b (a_b),
    .rsp     (a_rsp),
    .quo     (a_quo),
    .prod    (a_prod)
  );

endmodule

[sim/tb_infix_expression_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// Streams expressions into the evaluator one character per item. A built-in
// fixed-point calculator predicts the value and status of each expression,
// and a monitor compares every result item against the oldest prediction.
// The run covers directed corner cases, then random expressions under
// several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_infix_expression_evaluator;
  import iee_pkg::*;

  localparam int  VW        = 48;
  localparam int  FB        = 16;
  localparam int  MAX_FRAC  = 4;
  localparam int  DRAIN_CYC = 400;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VMIN = -(longint'(1) <<< (VW - 1));
  localparam logic [63:0] MANT_CAP = (64'd1 << VW) - 1;

  typedef struct {
    longint     val;
    logic [1:0] st;
  } answer_t;

  logic                 clk;
  logic                 rst;
  logic                 char_valid;
  logic                 char_stall;
  logic [7:0]           char_code;
  logic                 is_final;
  logic                 result_valid;
  logic                 result_stall;
  logic signed [VW-1:0] value;
  logic [1:0]           status;

  // Calculator state, mirrors the block's architectural state
  longint      sum_acc;
  longint      term_acc;
  logic [63:0] mant_acc;
  int          frac_cnt;
  bit          frac_mode;
  bit          term_minus;
  int          prod_op;      // 0 none, 1 multiply, 2 divide
  logic [1:0]  err_code;

  answer_t answers_due[$];
  int      fail_count;
  int      idle_pct;
  int      stall_pct;

  infix_expression_evaluator u_top (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .is_final     (is_final),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .status       (status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- calculator
  function automatic void clear_calc();
    sum_acc    = 0;
    term_acc   = 0;
    mant_acc   = '0;
    frac_cnt   = 0;
    frac_mode  = 1'b0;
    term_minus = 1'b0;
    prod_op    = 0;
    err_code   = ST_OK;
  endfunction

  function automatic void mark_overflow();
    if (err_code == ST_OK) err_code = ST_OVERFLOW;
  endfunction

  // Clamp a magnitude with sign into the value range, flagging overflow
  function automatic longint clamp_mag(bit negv, logic [127:0] mag);
    if (!negv) begin
      if (mag > 128'(VMAX)) begin
        mark_overflow();
        return VMAX;
      end
      return longint'(mag[63:0]);
    end
    if (mag > 128'(VMAX) + 1) begin
      mark_overflow();
      return VMIN;
    end
    return -longint'(mag[63:0]);
  endfunction

  function automatic longint clamp_sum(longint s);
    if (s > VMAX) begin
      mark_overflow();
      return VMAX;
    end
    if (s < VMIN) begin
      mark_overflow();
      return VMIN;
    end
    return s;
  endfunction

  function automatic logic [127:0] abs_mag(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // Turn the collected digits into a fixed-point operand and apply * or /
  function automatic void close_operand();
    logic [127:0] num;
    logic [127:0] den;
    longint       opnd;
    bit           negv;
    num = 128'(mant_acc) << FB;
    case (frac_cnt)
      0: den = 1;
      1: den = 10;
      2: den = 100;
      3: den = 1000;
      default: den = 10000;
    endcase
    num = num + den / 2;
    opnd = clamp_mag(1'b0, num / den);
    mant_acc  = '0;
    frac_cnt  = 0;
    frac_mode = 1'b0;
    negv = (term_acc < 0) != (opnd < 0);
    if (prod_op == 1) begin
      term_acc = clamp_mag(negv, (abs_mag(term_acc) * abs_mag(opnd)) >> FB);
    end else if (prod_op == 2) begin
      if (opnd == 0) begin
        err_code = ST_DIVZERO;
        return;
      end
      term_acc = clamp_mag(negv, (abs_mag(term_acc) << FB) / abs_mag(opnd));
    end else begin
      term_acc = opnd;
    end
  endfunction

  function automatic void close_term();
    sum_acc  = clamp_sum(term_minus ? sum_acc - term_acc : sum_acc + term_acc);
    term_acc = 0;
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic [63:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 64'(c - CH_ZERO);
      if (frac_mode) begin
        if (frac_cnt >= MAX_FRAC) return;
        frac_cnt++;
      end
      if (mant_acc > (MANT_CAP - d) / 10) begin
        mant_acc = MANT_CAP;
        mark_overflow();
      end else begin
        mant_acc = mant_acc * 10 + d;
      end
    end else if (c == CH_DOT) begin
      frac_mode = 1'b1;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      close_operand();
      if (err_code == ST_DIVZERO) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        close_term();
        term_minus = (c == CH_MINUS);
        prod_op    = 0;
      end else begin
        prod_op = (c == CH_STAR) ? 1 : 2;
      end
    end
  endfunction

  // Advance the calculator by one accepted item; queue an answer on the last one
  function automatic void eval_char(logic [7:0] c, logic last);
    answer_t a;
    if (err_code != ST_DIVZERO) take_char(c);
    if (!last) return;
    if (err_code != ST_DIVZERO) begin
      close_operand();
      if (err_code != ST_DIVZERO) close_term();
    end
    a.val = (err_code == ST_DIVZERO) ? 0 : sum_acc;
    a.st  = err_code;
    answers_due.push_back(a);
    clear_calc();
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what);
    fail_count++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    answer_t a;
    if (!rst && result_valid && !result_stall) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d", value, status));
      end else begin
        a = answers_due.pop_front();
        if (value !== a.val[VW-1:0])
          report_mismatch($sformatf("value %0d, want %0d", value, a.val));
        if (status !== a.st)
          report_mismatch($sformatf("status %0d, want %0d", status, a.st));
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- driving
  // Tasks enter and leave just after a falling edge.
  task automatic send_item(logic [7:0] c, logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      char_valid = 1'b0;
      @(negedge clk);
    end
    char_valid = 1'b1;
    char_code  = c;
    is_final   = last;
    do @(posedge clk); while (char_stall);
    eval_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_bytes(logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_item(q[i], i == q.size() - 1);
  endtask

  // Hold the sender until every answer is back, then let the block settle
  task automatic drain();
    char_valid = 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Random expression: mostly well formed, with some noise and broken pieces
  task automatic build_expr(output logic [7:0] q[$]);
    int n_ops;
    int nd;
    logic [7:0] ops[4];
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    q = {};
    n_ops = $urandom_range(4);
    if ($urandom_range(9) == 0) q.push_back(CH_MINUS);
    for (int k = 0; k <= n_ops; k++) begin
      nd = ($urandom_range(19) == 0) ? $urandom_range(17) : $urandom_range(1, 3);
      for (int i = 0; i < nd; i++) q.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(2) == 0) begin
        q.push_back(CH_DOT);
        nd = $urandom_range(6);
        for (int i = 0; i < nd; i++) q.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(19) == 0) q.push_back(CH_DOT);
      end
      if ($urandom_range(5) == 0) q.push_back(CH_SPACE);
      if ($urandom_range(14) == 0) q.push_back(8'($urandom_range(255)));
      if (k < n_ops) begin
        q.push_back(ops[$urandom_range(3)]);
        if ($urandom_range(14) == 0) q.push_back(ops[$urandom_range(3)]);
      end
    end
    if ($urandom_range(19) == 0) q.push_back(ops[$urandom_range(3)]);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_precedence();
    send_text("1+2*3");
    send_text("10-4/2*3");
    send_text("2*3+4*5-6/3");
    send_text("10/3");
    send_text("7 - 12 . 5");
    drain();
  endtask

  task automatic test_special_cases();
    send_text("-5");             // leading minus negates
    send_text("3*");             // trailing operator applies zero
    send_text("4+-2");           // doubled operator
    send_text("1.234567");       // excess fraction digits dropped
    send_text("1.2.5");          // second point ignored
    send_text("999999999999999999"); // mantissa saturates
    send_text("100000*100000");  // product saturates
    send_text("0-100000*100000"); // negative saturation
    send_text("7/0+3*9");        // divide by zero, rest ignored
    send_text("8/0.00001");      // divisor rounds to zero
    send_text("0.0001");         // conversion rounds to nearest
    send_item(8'hFF, 1'b0);      // noise characters
    send_item(8'h00, 1'b0);
    send_item(8'h41, 1'b1);
    send_item(CH_SPACE, 1'b1);   // empty expression
    drain();
  endtask

  task automatic test_random(int n_chars, int idle, int stall);
    logic [7:0] q[$];
    int sent;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_chars) begin
      build_expr(q);
      send_bytes(q);
      sent += q.size();
      // Hold the sender once mid-phase until all answers are back
      if (sent > n_chars / 2 && sent - q.size() <= n_chars / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst          = 1'b1;
    char_valid   = 1'b0;
    char_code    = '0;
    is_final     = 1'b0;
    result_stall = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    fail_count   = 0;
    clear_calc();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_precedence();
    test_special_cases();
    test_random(470, 0, 0);
    test_random(470, 74, 0);
    test_random(470, 0, 74);
    test_random(470, 10, 10);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
